/* src/rws_pkg.sv */
// Shared types and constants of the steered 2D random walker.
// Used by the controller, the datapath, its arithmetic units and the top level.
`default_nettype none

package rws_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int COORD_BITS = 24;
	localparam int RAND_BITS  = 16;
	localparam int DEV_BITS   = 8;
	localparam int SPEED_BITS = 23;

	// Working vector components hold the sum of two coordinates.
	localparam int W_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * W_BITS;
	localparam int SUM_BITS  = PROD_BITS;
	localparam int SQ_BITS   = SUM_BITS + 8;
	localparam int ROOT_BITS = SQ_BITS / 2;
	localparam int NUM_BITS  = 52;
	localparam int DEN_BITS  = ROOT_BITS;
	// Offset numerator: deviation times the fraction distance plus the rounding term.
	localparam int OFF_BITS  = DEV_BITS + FRAC_BITS + RAND_BITS + 1;

	localparam logic [RAND_BITS:0] RMAX = {1'b0, {RAND_BITS{1'b1}}};

	typedef enum logic [2:0] {
		CFG_MODE,
		CFG_DEV,
		CFG_SPEED,
		CFG_MAXSP,
		CFG_BOUNDX,
		CFG_BOUNDY,
		CFG_MINX,
		CFG_MINY
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PLACE,
		OP_OFF_MUL,
		OP_OFF_DIV,
		OP_OFF_END,
		OP_SQ,
		OP_SUM,
		OP_MAXSQ,
		OP_SQRT,
		OP_ZERO,
		OP_SCL_MUL,
		OP_SCL_DIV,
		OP_SCL_END,
		OP_ACCD,
		OP_VELD,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PLACE,
		ST_OMUL,
		ST_ODIV,
		ST_OEND,
		ST_SQ,
		ST_SUM,
		ST_MAXSQ,
		ST_CMP,
		ST_SQRT,
		ST_SWAIT,
		ST_ZERO,
		ST_SMUL,
		ST_SDIV,
		ST_DWAIT,
		ST_SEND,
		ST_ACCD,
		ST_VELD,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic axis;   // 0 x component, 1 y component
		logic phase;  // 0 acceleration, 1 velocity
		logic load;   // capture the input item
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic root_zero;
		logic over;
	} stat_t;

endpackage

`default_nettype wire

/* src/random_walker_step_2d.sv */
// Steered 2D random walker, signed fixed point with 8 fraction bits.
// Input items arrive on the s_axis stream, one result item per input item leaves
// on the m_axis stream; eight registers are written through the cfg port.
// tuser carries the command: 0 takes a walk step, 1 places the walker.
// A place item sets the location directly. A walk item runs the offset,
// the steering length and the acceleration scaling, plus the velocity scaling
// when the velocity cap applies; a zero steering sum skips the acceleration
// scaling. Each scaling takes a square root and two bit-serial divisions.
// One item is worked on at a time; s_axis_tready is high only when the block
// is free. The result sits in an output register, so the next item is accepted
// while the previous result waits; a stalled receiver holds the block in its
// final step only if a second result is ready before the first is taken.
// Reset clears location, velocity and acceleration and loads the default
// registers. cfg_ready is always high; write registers only while idle.
// Depends on rws_pkg, rws_ctrl and rws_dp.
`default_nettype none

module random_walker_step_2d (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,   // rand_x, rand_y, place_x, place_y
	input  wire logic [0:0]  s_axis_tuser,   // cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata,   // pos_x, pos_y
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [rws_pkg::COORD_BITS-1:0] cfg_data
);
	import rws_pkg::*;

	cmd_t                  cmd;
	stat_t                 stat;
	logic [COORD_BITS-1:0] pos_x, pos_y;

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rand_x    (s_axis_tdata[15:0]),
		.rand_y    (s_axis_tdata[31:16]),
		.place_x   (s_axis_tdata[55:32]),
		.place_y   (s_axis_tdata[79:56]),
		.pos_x     (pos_x),
		.pos_y     (pos_y)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {pos_y, pos_x};

endmodule

`default_nettype wire

/* src/rws_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rws_pkg for its widths.
`default_nettype none

module rws_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rws_pkg::NUM_BITS-1:0] num,
	input  wire logic [rws_pkg::DEN_BITS-1:0] den,
	output logic      [rws_pkg::NUM_BITS-1:0] quo,
	output logic                              done
);
	import rws_pkg::*;

	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DEN_BITS:0]   trial;
	logic                ge;

	assign trial = {rem_q, num_q[NUM_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(NUM_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_BITS-2:0], ge};
			if (ge) begin
				rem_q <= DEN_BITS'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_BITS-1:0];
			end
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* src/rws_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on rws_pkg for its widths.
`default_nettype none

module rws_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rws_pkg::SQ_BITS-1:0]   radicand,
	output logic      [rws_pkg::ROOT_BITS-1:0] root,
	output logic                               done
);
	import rws_pkg::*;

	localparam int CNT_BITS = $clog2(ROOT_BITS + 1);
	localparam int REM_BITS = ROOT_BITS + 2;

	logic [SQ_BITS-1:0]   x_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 done_q;
	logic [REM_BITS+1:0]  t;
	logic [REM_BITS+1:0]  tr;
	logic                 ge;

	assign t  = {rem_q, x_q[SQ_BITS-1 -: 2]};
	assign tr = (REM_BITS + 2)'({root_q, 2'b01});
	assign ge = t >= tr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(ROOT_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= {x_q[SQ_BITS-3:0], 2'b00};
			root_q <= {root_q[ROOT_BITS-2:0], ge};
			if (ge) begin
				rem_q <= REM_BITS'(t - tr);
			end else begin
				rem_q <= t[REM_BITS-1:0];
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* src/rws_dp.sv */
// Datapath of the random walker: configuration, walker state, shared multiplier,
// divider and square root. Depends on rws_pkg, rws_div and rws_sqrt.
`default_nettype none

module rws_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rws_pkg::cmd_t                  cmd,
	output rws_pkg::stat_t                      stat,
	input  wire logic                           cfg_we,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [rws_pkg::COORD_BITS-1:0] cfg_data,
	input  wire logic [rws_pkg::RAND_BITS-1:0]  rand_x,
	input  wire logic [rws_pkg::RAND_BITS-1:0]  rand_y,
	input  wire logic [rws_pkg::COORD_BITS-1:0] place_x,
	input  wire logic [rws_pkg::COORD_BITS-1:0] place_y,
	output logic      [rws_pkg::COORD_BITS-1:0] pos_x,
	output logic      [rws_pkg::COORD_BITS-1:0] pos_y
);
	import rws_pkg::*;

	localparam int CB = COORD_BITS;

	// Configuration registers
	logic                  mode_q;
	logic [DEV_BITS-1:0]   dev_q;
	logic [SPEED_BITS-1:0] speed_q;
	logic [SPEED_BITS-1:0] maxsp_q;
	logic [CB-1:0]         bound_x_q, bound_y_q, min_x_q, min_y_q;

	// Walker state
	logic signed [CB-1:0] loc_x_q, loc_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;

	// Working registers
	logic [RAND_BITS-1:0]  rand_x_q, rand_y_q;
	logic [CB-1:0]         place_x_q, place_y_q;
	logic signed [W_BITS-1:0] wx_q, wy_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic                  sgn_q;
	logic [CB-1:0]         pos_x_q, pos_y_q;
	logic [OFF_BITS-1:0]   on_q, oq_q;

	logic signed [W_BITS-1:0]   w_sel;
	logic [W_BITS-1:0]          w_abs;
	logic [RAND_BITS-1:0]       r_sel;
	logic signed [RAND_BITS+2:0] diff;
	logic [RAND_BITS+2:0]       d_abs;
	logic [SPEED_BITS-1:0]      len;
	logic [W_BITS-1:0]          mul_a, mul_b;
	logic [PROD_BITS-1:0]       prod_d;
	logic [NUM_BITS-1:0]        div_num, quo;
	logic [DEN_BITS-1:0]        div_den;
	logic                       div_start, div_done;
	logic [ROOT_BITS-1:0]       root;
	logic                       sqrt_done;
	logic [OFF_BITS-1:0]        on_sum, on_d, oq_d, orem;
	logic [W_BITS-1:0]          off_mag;
	logic signed [W_BITS-1:0]   off_val, base, off_sum;
	logic [CB-1:0]              scl_val;

	function automatic logic [CB-1:0] sat_w(input logic [W_BITS-1:0] w);
		logic [CB-1:0] r;
		if (w[W_BITS-1] != w[W_BITS-2]) begin
			r = w[W_BITS-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end else begin
			r = w[CB-1:0];
		end
		return r;
	endfunction

	// Add velocity to location and wrap between lo and hi.
	function automatic logic [CB-1:0] wrap(input logic [CB-1:0] p0, input logic [CB-1:0] v,
			input logic [CB-1:0] lo, input logic [CB-1:0] hi);
		logic signed [W_BITS-1:0] p, lo_e, hi_e;
		p    = $signed({p0[CB-1], p0}) + $signed({v[CB-1], v});
		lo_e = $signed({lo[CB-1], lo});
		hi_e = $signed({hi[CB-1], hi});
		if (p > hi_e) begin
			p = lo_e;
		end
		if (p < lo_e) begin
			p = hi_e;
		end
		return p[CB-1:0];
	endfunction

	assign w_sel = cmd.axis ? wy_q : wx_q;
	assign w_abs = w_sel[W_BITS-1] ? (~w_sel + 1'b1) : w_sel;
	assign r_sel = cmd.axis ? rand_y_q : rand_x_q;
	assign diff  = $signed({2'b00, r_sel, 1'b0}) - $signed({2'b00, RMAX});
	assign d_abs = diff[RAND_BITS+2] ? (~diff + 1'b1) : diff;
	assign len   = cmd.phase ? maxsp_q : speed_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_OFF_MUL: begin
				mul_a = W_BITS'({dev_q, {FRAC_BITS{1'b0}}});
				mul_b = W_BITS'(d_abs);
			end
			OP_SQ: begin
				mul_a = w_abs;
				mul_b = w_abs;
			end
			OP_SCL_MUL: begin
				mul_a = w_abs;
				mul_b = W_BITS'(len);
			end
			OP_MAXSQ: begin
				mul_a = W_BITS'(maxsp_q);
				mul_b = W_BITS'(maxsp_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// Offset division by the all-ones fraction scale. Straight mode divides by twice
	// the scale, which is the same as halving the rounded numerator first. The
	// estimate n * (1 + 2^-16) / 2^16 is at most one below the true quotient, and
	// the remainder check in the next step settles that last unit.
	assign on_sum = OFF_BITS'(prod_q) + (mode_q ? OFF_BITS'(RMAX >> 1) : OFF_BITS'(RMAX));
	assign on_d   = mode_q ? on_sum : (on_sum >> 1);
	assign oq_d   = (on_d + (on_d >> RAND_BITS)) >> RAND_BITS;

	assign orem    = on_q - {oq_q[OFF_BITS-RAND_BITS-1:0], {RAND_BITS{1'b0}}} + oq_q;
	assign off_mag = W_BITS'(oq_q + OFF_BITS'(orem >= OFF_BITS'(RMAX)));

	always_comb begin
		div_num   = '0;
		div_den   = '0;
		div_start = 1'b0;
		if (cmd.op == OP_SCL_DIV) begin
			div_start = 1'b1;
			div_den   = root;
			div_num   = {prod_q[NUM_BITS-5:0], 4'b0000} + NUM_BITS'(root >> 1);
		end
	end

	rws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.done   (div_done)
	);

	rws_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT),
		.radicand ({sum_q, 8'h00}),
		.root     (root),
		.done     (sqrt_done)
	);

	assign off_val = sgn_q ? -$signed(off_mag) : $signed(off_mag);

	always_comb begin
		if (mode_q) begin
			base = cmd.axis ? W_BITS'(acc_y_q) : W_BITS'(acc_x_q);
		end else begin
			base = cmd.axis ? W_BITS'(4 << FRAC_BITS) : W_BITS'(2 << FRAC_BITS);
		end
	end

	assign off_sum = base + off_val;

	// Rounded quotient back to a signed coordinate, saturated.
	always_comb begin
		if (!sgn_q) begin
			scl_val = (quo > NUM_BITS'({1'b0, {(CB-1){1'b1}}})) ?
				{1'b0, {(CB-1){1'b1}}} : quo[CB-1:0];
		end else begin
			scl_val = (quo > NUM_BITS'({1'b1, {(CB-1){1'b0}}})) ?
				{1'b1, {(CB-1){1'b0}}} : (~quo[CB-1:0] + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			dev_q     <= DEV_BITS'(10);
			speed_q   <= SPEED_BITS'(256);
			maxsp_q   <= SPEED_BITS'(3072);
			bound_x_q <= CB'(25600);
			bound_y_q <= CB'(25600);
			min_x_q   <= '0;
			min_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:   mode_q    <= cfg_data[0];
				CFG_DEV:    dev_q     <= cfg_data[DEV_BITS-1:0];
				CFG_SPEED:  speed_q   <= cfg_data[SPEED_BITS-1:0];
				CFG_MAXSP:  maxsp_q   <= cfg_data[SPEED_BITS-1:0];
				CFG_BOUNDX: bound_x_q <= cfg_data;
				CFG_BOUNDY: bound_y_q <= cfg_data;
				CFG_MINX:   min_x_q   <= cfg_data;
				CFG_MINY:   min_y_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_x_q <= '0;
			loc_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_PLACE: begin
					loc_x_q <= place_x_q;
					loc_y_q <= place_y_q;
					vel_x_q <= '0;
					vel_y_q <= '0;
					acc_x_q <= '0;
					acc_y_q <= '0;
				end
				OP_ACCD: begin
					acc_x_q <= wx_q[CB-1:0];
					acc_y_q <= wy_q[CB-1:0];
				end
				OP_VELD: begin
					vel_x_q <= sat_w(wx_q);
					vel_y_q <= sat_w(wy_q);
					loc_x_q <= wrap(loc_x_q, sat_w(wx_q), min_x_q, bound_x_q);
					loc_y_q <= wrap(loc_y_q, sat_w(wy_q), min_y_q, bound_y_q);
				end
				default: begin
					loc_x_q <= loc_x_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rand_x_q  <= rand_x;
			rand_y_q  <= rand_y;
			place_x_q <= place_x;
			place_y_q <= place_y;
		end
		unique case (cmd.op)
			OP_OFF_MUL: begin
				prod_q <= prod_d;
				sgn_q  <= diff[RAND_BITS+2];
			end
			OP_OFF_DIV: begin
				on_q <= on_d;
				oq_q <= oq_d;
			end
			OP_SCL_MUL: begin
				prod_q <= prod_d;
				sgn_q  <= w_sel[W_BITS-1];
			end
			OP_SQ, OP_MAXSQ: begin
				prod_q <= prod_d;
			end
			OP_SUM: begin
				sum_q <= cmd.axis ? (sum_q + prod_q) : prod_q;
			end
			OP_OFF_END: begin
				if (cmd.axis) begin
					wy_q <= off_sum;
				end else begin
					wx_q <= off_sum;
				end
			end
			OP_SCL_END: begin
				if (cmd.axis) begin
					wy_q <= W_BITS'($signed(scl_val));
				end else begin
					wx_q <= W_BITS'($signed(scl_val));
				end
			end
			OP_ZERO: begin
				wx_q <= '0;
				wy_q <= '0;
			end
			OP_ACCD: begin
				// The new acceleration is added to the old velocity.
				wx_q <= W_BITS'(vel_x_q) + wx_q;
				wy_q <= W_BITS'(vel_y_q) + wy_q;
			end
			OP_OUT: begin
				pos_x_q <= loc_x_q;
				pos_y_q <= loc_y_q;
			end
			default: begin
				sgn_q <= sgn_q;
			end
		endcase
	end

	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.root_zero = (root == '0);
	assign stat.over      = sum_q > prod_q;

	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;

endmodule

`default_nettype wire

/* src/rws_ctrl.sv */
// Controller of the random walker: sequences the datapath operations of one item
// and runs both stream handshakes. Depends on rws_pkg.
`default_nettype none

module rws_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire rws_pkg::stat_t stat,
	output rws_pkg::cmd_t       cmd
);
	import rws_pkg::*;

	state_t state_q, state_d;
	logic   axis_q, phase_q, out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) begin
				state_d = in_cmd ? ST_PLACE : ST_OMUL;
			end
			ST_PLACE: state_d = ST_OUT;
			ST_OMUL:  state_d = ST_ODIV;
			ST_ODIV:  state_d = ST_OEND;
			ST_OEND:  state_d = axis_q ? ST_SQ : ST_OMUL;
			ST_SQ:    state_d = ST_SUM;
			ST_SUM: begin
				if (!axis_q) begin
					state_d = ST_SQ;
				end else begin
					state_d = phase_q ? ST_MAXSQ : ST_SQRT;
				end
			end
			ST_MAXSQ: state_d = ST_CMP;
			ST_CMP:   state_d = stat.over ? ST_SQRT : ST_VELD;
			ST_SQRT:  state_d = ST_SWAIT;
			ST_SWAIT: if (stat.sqrt_done) begin
				state_d = stat.root_zero ? ST_ZERO : ST_SMUL;
			end
			ST_ZERO:  state_d = phase_q ? ST_VELD : ST_ACCD;
			ST_SMUL:  state_d = ST_SDIV;
			ST_SDIV:  state_d = ST_DWAIT;
			ST_DWAIT: if (stat.div_done) begin
				state_d = ST_SEND;
			end
			ST_SEND: begin
				if (!axis_q) begin
					state_d = ST_SMUL;
				end else begin
					state_d = phase_q ? ST_VELD : ST_ACCD;
				end
			end
			ST_ACCD:  state_d = ST_SQ;
			ST_VELD:  state_d = ST_OUT;
			ST_OUT:   if (out_free) begin
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.axis  = axis_q;
		cmd.phase = phase_q;
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_PLACE: cmd.op = OP_PLACE;
			ST_OMUL:  cmd.op = OP_OFF_MUL;
			ST_ODIV:  cmd.op = OP_OFF_DIV;
			ST_OEND:  cmd.op = OP_OFF_END;
			ST_SQ:    cmd.op = OP_SQ;
			ST_SUM:   cmd.op = OP_SUM;
			ST_MAXSQ: cmd.op = OP_MAXSQ;
			ST_SQRT:  cmd.op = OP_SQRT;
			ST_ZERO:  cmd.op = OP_ZERO;
			ST_SMUL:  cmd.op = OP_SCL_MUL;
			ST_SDIV:  cmd.op = OP_SCL_DIV;
			ST_SEND:  cmd.op = OP_SCL_END;
			ST_ACCD:  cmd.op = OP_ACCD;
			ST_VELD:  cmd.op = OP_VELD;
			ST_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Axis toggles after each per-component step; phase moves on once the
			// acceleration is settled.
			unique case (state_q)
				ST_IDLE: begin
					axis_q  <= 1'b0;
					phase_q <= 1'b0;
				end
				ST_OEND, ST_SUM, ST_SEND: axis_q <= ~axis_q;
				ST_ACCD: phase_q <= 1'b1;
				default: axis_q <= axis_q;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
